FILE: hdl/clsup_pkg.sv
// Shared types and constants for the cellular link supervisor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package clsup_pkg;

	localparam int unsigned NOW_W      = 32;
	localparam int unsigned BEARER_W   = 8;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned HB_W       = 16;
	localparam int unsigned RTO_W      = 16;
	localparam int unsigned RRD_W      = 8;
	localparam int unsigned WD_W       = 19;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W  = 48;
	localparam int unsigned M_TDATA_W  = 40;

	localparam logic [BEARER_W-1:0] BEARER_ACTIVE  = 8'd4;
	localparam logic [WD_W-1:0]     WATCHDOG_SLACK = 19'd5;
	localparam logic [HB_W-1:0]     HB_RST         = 16'hFFFF;
	localparam logic [RTO_W-1:0]    RTO_RST        = 16'd90;
	localparam logic [RRD_W-1:0]    RRD_RST        = 8'd5;
	// 7 * 0xFFFF + 5
	localparam logic [WD_W-1:0]     WD_BOUND_RST   = 19'd458750;

	typedef enum logic [2:0] {
		ST_INIT       = 3'd0,
		ST_REGISTERED = 3'd1,
		ST_ACTIVATED  = 3'd2,
		ST_RUNNING    = 3'd3,
		ST_FAILED     = 3'd4
	} link_state_t;

	typedef enum logic {
		OP_TICK     = 1'b0,
		OP_TEARDOWN = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEARTBEAT   = 2'd0,
		CFG_REG_TIMEOUT = 2'd1,
		CFG_REREG_DELAY = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [RTO_W-1:0] register_timeout;
		logic [RRD_W-1:0] reregister_delay;
		logic [WD_W-1:0]  wd_bound;
	} cfg_t;

	typedef struct packed {
		op_t                 operation;
		logic [NOW_W-1:0]    now;
		logic                service_available;
		logic [BEARER_W-1:0] bearer_status;
	} item_t;

	typedef struct packed {
		link_state_t        link_state;
		logic               link_ok;
		logic [COUNT_W-1:0] reg_count;
		logic               apn_setup_pulse;
		logic               teardown_pulse;
		logic               service_tick_pulse;
		logic               reboot_request;
	} result_t;

endpackage

FILE: hdl/clsup_cfg.sv
// Configuration registers of the link supervisor, with the watchdog bound
// precomputed on write. Depends on clsup_pkg.
`timescale 1ns / 1ps

module clsup_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [clsup_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clsup_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output clsup_pkg::cfg_t                      cfg
);

	logic [clsup_pkg::RTO_W-1:0] rto_q;
	logic [clsup_pkg::RRD_W-1:0] rrd_q;
	logic [clsup_pkg::WD_W-1:0]  wd_bound_q;
	logic [clsup_pkg::WD_W-1:0]  hb_ext;
	logic [clsup_pkg::WD_W-1:0]  wd_bound_new;

	// 7 * hb + 5 as (hb << 3) - hb + 5
	assign hb_ext       = clsup_pkg::WD_W'(cfg_wdata[clsup_pkg::HB_W-1:0]);
	assign wd_bound_new = (hb_ext << 3) - hb_ext + clsup_pkg::WATCHDOG_SLACK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rto_q      <= clsup_pkg::RTO_RST;
			rrd_q      <= clsup_pkg::RRD_RST;
			wd_bound_q <= clsup_pkg::WD_BOUND_RST;
		end else if (cfg_we) begin
			unique case (clsup_pkg::cfg_idx_t'(cfg_index))
				clsup_pkg::CFG_HEARTBEAT:   wd_bound_q <= wd_bound_new;
				clsup_pkg::CFG_REG_TIMEOUT: rto_q <= cfg_wdata[clsup_pkg::RTO_W-1:0];
				clsup_pkg::CFG_REREG_DELAY: rrd_q <= cfg_wdata[clsup_pkg::RRD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.register_timeout = rto_q;
	assign cfg.reregister_delay = rrd_q;
	assign cfg.wd_bound         = wd_bound_q;

endmodule

FILE: hdl/clsup_step.sv
// Link state machine: state, timestamps and registration counter, with the
// per-beat next-state and result logic. Depends on clsup_pkg.
`timescale 1ns / 1ps

module clsup_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  clsup_pkg::item_t    item,
	input  clsup_pkg::cfg_t     cfg,
	output clsup_pkg::result_t  res
);

	clsup_pkg::link_state_t              state_q, state_d;
	logic [clsup_pkg::NOW_W-1:0]         failed_stamp_q, failed_stamp_d;
	logic [clsup_pkg::NOW_W-1:0]         apn_stamp_q, apn_stamp_d;
	logic [clsup_pkg::NOW_W-1:0]         good_stamp_q, good_stamp_d;
	logic [clsup_pkg::COUNT_W-1:0]       count_q, count_d;
	logic [clsup_pkg::NOW_W-1:0]         since_failed, since_apn, since_good;
	logic [clsup_pkg::NOW_W-1:0]         rto_ext, rrd_ext, wd_ext;
	logic                                apn_p, tear_p, svc_p, reboot_p;

	assign since_failed = item.now - failed_stamp_q;
	assign since_apn    = item.now - apn_stamp_q;
	assign since_good   = item.now - good_stamp_q;
	assign rto_ext      = clsup_pkg::NOW_W'(cfg.register_timeout);
	assign rrd_ext      = clsup_pkg::NOW_W'(cfg.reregister_delay);
	assign wd_ext       = clsup_pkg::NOW_W'(cfg.wd_bound);

	always_comb begin
		state_d        = state_q;
		failed_stamp_d = failed_stamp_q;
		apn_stamp_d    = apn_stamp_q;
		good_stamp_d   = good_stamp_q;
		count_d        = count_q;
		apn_p          = 1'b0;
		tear_p         = 1'b0;
		svc_p          = 1'b0;
		reboot_p       = 1'b0;
		if (item.operation == clsup_pkg::OP_TEARDOWN) begin
			tear_p = 1'b1;
		end else begin
			unique case (state_q)
				clsup_pkg::ST_INIT: begin
					if (item.service_available) begin
						apn_stamp_d = item.now;
						count_d     = count_q + clsup_pkg::COUNT_W'(1);
						state_d     = clsup_pkg::ST_REGISTERED;
						apn_p       = 1'b1;
					end else if (since_failed > rto_ext) begin
						tear_p = 1'b1;
					end
				end
				clsup_pkg::ST_REGISTERED: begin
					if (item.bearer_status == clsup_pkg::BEARER_ACTIVE) begin
						state_d = clsup_pkg::ST_ACTIVATED;
					end else if (since_apn > rto_ext) begin
						tear_p = 1'b1;
					end
				end
				clsup_pkg::ST_ACTIVATED: begin
					state_d = clsup_pkg::ST_RUNNING;
				end
				clsup_pkg::ST_RUNNING: begin
					good_stamp_d = item.now;
					svc_p        = 1'b1;
				end
				clsup_pkg::ST_FAILED: begin
					if (since_good > wd_ext) begin
						reboot_p = 1'b1;
					end else if (since_failed >= rrd_ext) begin
						state_d = clsup_pkg::ST_INIT;
					end
				end
				default: ;
			endcase
		end
		if (tear_p) begin
			failed_stamp_d = item.now;
			state_d        = clsup_pkg::ST_FAILED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= clsup_pkg::ST_INIT;
			failed_stamp_q <= '0;
			apn_stamp_q    <= '0;
			good_stamp_q   <= '0;
			count_q        <= '0;
		end else if (fire) begin
			state_q        <= state_d;
			failed_stamp_q <= failed_stamp_d;
			apn_stamp_q    <= apn_stamp_d;
			good_stamp_q   <= good_stamp_d;
			count_q        <= count_d;
		end
	end

	assign res.link_state         = state_d;
	assign res.link_ok            = (state_d == clsup_pkg::ST_RUNNING);
	assign res.reg_count          = count_d;
	assign res.apn_setup_pulse    = apn_p;
	assign res.teardown_pulse     = tear_p;
	assign res.service_tick_pulse = svc_p;
	assign res.reboot_request     = reboot_p;

endmodule

FILE: hdl/cellular_link_supervisor_core.sv
// Cellular link supervisor top level: input beat register, state step and
// result register. Depends on clsup_pkg, clsup_cfg and clsup_step.
//
// Usage:
//   Each input beat is a periodic tick (s_tuser = 0) carrying the clock in
//   seconds, service availability and bearer status, or a teardown request
//   (s_tuser = 1). Every input beat yields exactly one output beat with the
//   state after the beat, the link-ok flag, the registration count and the
//   action pulses.
//   A beat accepted is registered in the input register, stepped through the
//   state machine as it moves into the result register and presented on
//   m_tdata from there. One beat per cycle is taken while m_tready is high,
//   set by the single state register update per beat.
//   Configuration writes take effect at the edge they are written; the user
//   must make them while no beat is in flight (the block does not enforce it).
//   Reset clears the state to init, all timestamps and the counter to zero,
//   loads the register defaults and empties both beat registers.
//   When m_tready is low the result register holds; one more beat is taken
//   into the input register, then s_tready drops until the result leaves.
`timescale 1ns / 1ps

module cellular_link_supervisor_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [31:0] now, [32] service_available, [40:33] bearer_status, [47:41] zero
	input  logic [clsup_pkg::S_TDATA_W-1:0]       s_tdata,
	// [0] operation
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [2:0] link_state, [3] link_ok, [35:4] reg_count, [36] apn_setup_pulse,
	// [37] teardown_pulse, [38] service_tick_pulse, [39] reboot_request
	output logic [clsup_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                  cfg_we,
	input  logic [clsup_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [clsup_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	clsup_pkg::item_t    item_s1;
	clsup_pkg::item_t    item_in;
	clsup_pkg::result_t  res_comb;
	clsup_pkg::result_t  res_s2;
	clsup_pkg::cfg_t     cfg;
	logic                valid_s1;
	logic                valid_s2;
	logic                fire;
	logic                accept;

	assign item_in.operation         = clsup_pkg::op_t'(s_tuser);
	assign item_in.now               = s_tdata[31:0];
	assign item_in.service_available = s_tdata[32];
	assign item_in.bearer_status     = s_tdata[40:33];

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	clsup_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	clsup_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.reboot_request, res_s2.service_tick_pulse,
		res_s2.teardown_pulse, res_s2.apn_setup_pulse, res_s2.reg_count,
		res_s2.link_ok, res_s2.link_state};

endmodule

FILE: hdl/clsup_checker.sv
// Port-level checks for the cellular link supervisor, bound to the top level.
// Depends on clsup_pkg and cellular_link_supervisor_core.
`timescale 1ns / 1ps

module clsup_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [clsup_pkg::M_TDATA_W-1:0]    m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3] == (m_tdata[2:0] == clsup_pkg::ST_RUNNING))
		else $error("link_ok disagrees with state");

	a_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[39:36]))
		else $error("more than one action pulse");

	a_tear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37] |-> m_tdata[2:0] == clsup_pkg::ST_FAILED)
		else $error("teardown without failed state");

	a_apn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |-> m_tdata[2:0] == clsup_pkg::ST_REGISTERED)
		else $error("apn setup without registered state");

endmodule

bind cellular_link_supervisor_core clsup_checker u_clsup_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/cellular_link_supervisor_core_tb.sv
// Self-checking bench for cellular_link_supervisor_core: drives tick and teardown beats,
// predicts each result beat from its own model of the link state machine and compares fields.
// Depends on clsup_pkg and the core RTL only.
`timescale 1ns / 1ps

module cellular_link_supervisor_core_tb;
	import clsup_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam logic [31:0] HEARTBEATS_TO_REBOOT = 32'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cellular_link_supervisor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// supervisor model state and settings
	logic [HB_W-1:0] hb_period = HB_RST;
	logic [RTO_W-1:0] reg_timeout = RTO_RST;
	logic [RRD_W-1:0] rereg_delay = RRD_RST;
	link_state_t sv_state = ST_INIT;
	logic [31:0] fail_stamp = '0;
	logic [31:0] apn_stamp = '0;
	logic [31:0] good_stamp = '0;
	logic [31:0] attach_count = '0;

	result_t link_reports_due[$];
	logic [31:0] wall_clock = '0;
	int mismatches = 0;
	int cycle_count = 0;
	bit idling = 1'b1;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] reboot_bound();
		return HEARTBEATS_TO_REBOOT * {16'd0, hb_period} + 32'(WATCHDOG_SLACK);
	endfunction

	function automatic result_t step_supervisor(input op_t op, input logic [31:0] stamp,
			input logic avail, input logic [7:0] bearer);
		result_t r;
		logic [31:0] since_fail;
		logic [31:0] since_apn;
		logic [31:0] since_good;
		r = '0;
		since_fail = stamp - fail_stamp;
		since_apn = stamp - apn_stamp;
		since_good = stamp - good_stamp;
		if (op == OP_TEARDOWN) begin
			fail_stamp = stamp;
			sv_state = ST_FAILED;
			r.teardown_pulse = 1'b1;
		end else begin
			case (sv_state)
				ST_INIT: begin
					if (avail) begin
						apn_stamp = stamp;
						attach_count = attach_count + 32'd1;
						sv_state = ST_REGISTERED;
						r.apn_setup_pulse = 1'b1;
					end else if (since_fail > {16'd0, reg_timeout}) begin
						fail_stamp = stamp;
						sv_state = ST_FAILED;
						r.teardown_pulse = 1'b1;
					end
				end
				ST_REGISTERED: begin
					if (bearer == BEARER_ACTIVE) begin
						sv_state = ST_ACTIVATED;
					end else if (since_apn > {16'd0, reg_timeout}) begin
						fail_stamp = stamp;
						sv_state = ST_FAILED;
						r.teardown_pulse = 1'b1;
					end
				end
				ST_ACTIVATED: sv_state = ST_RUNNING;
				ST_RUNNING: begin
					good_stamp = stamp;
					r.service_tick_pulse = 1'b1;
				end
				ST_FAILED: begin
					if (since_good > reboot_bound()) begin
						r.reboot_request = 1'b1;
					end else if (since_fail >= {24'd0, rereg_delay}) begin
						sv_state = ST_INIT;
					end
				end
				default: ;
			endcase
		end
		r.link_state = sv_state;
		r.link_ok = (sv_state == ST_RUNNING);
		r.reg_count = attach_count;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch %0d at %0t: %s got %0h, expected %0h", mismatches, $realtime, field,
			got, want);
	endtask

	task automatic send_beat(input op_t op, input logic [31:0] stamp, input logic avail,
			input logic [7:0] bearer);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		link_reports_due.push_back(step_supervisor(op, stamp, avail, bearer));
		s_tdata <= {7'd0, bearer, avail, stamp};
		s_tuser <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_session_beat();
		op_t op;
		logic avail;
		logic [7:0] bearer;
		case ($urandom_range(0, 49))
			0: wall_clock = $urandom();
			1: wall_clock = good_stamp + $urandom_range(0, 8);
			2: wall_clock = good_stamp + reboot_bound() + $urandom_range(0, 1);
			3: wall_clock = fail_stamp + {24'd0, rereg_delay} - $urandom_range(0, 1);
			4: wall_clock = apn_stamp + {16'd0, reg_timeout} + $urandom_range(0, 1);
			5: wall_clock = fail_stamp + {16'd0, reg_timeout} + $urandom_range(0, 1);
			6: wall_clock = wall_clock + $urandom_range(0, 600000);
			default: wall_clock = wall_clock + $urandom_range(0, 3);
		endcase
		// pull the clock back so a tripped watchdog does not hold the link down for good
		if (sv_state == ST_FAILED && (wall_clock - good_stamp) > reboot_bound()
				&& $urandom_range(0, 7) == 0)
			wall_clock = good_stamp + $urandom_range(0, 8);
		op = ($urandom_range(0, 19) == 0) ? OP_TEARDOWN : OP_TICK;
		avail = (sv_state == ST_INIT) ? ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1));
		bearer = (sv_state == ST_REGISTERED && $urandom_range(0, 1) == 1) ? BEARER_ACTIVE
			: 8'($urandom_range(0, 255));
		send_beat(op, wall_clock, avail, bearer);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (link_reports_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] hb, input logic [15:0] rto,
			input logic [7:0] rrd);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEARTBEAT;
		cfg_wdata <= hb;
		@(posedge clk);
		cfg_index <= CFG_REG_TIMEOUT;
		cfg_wdata <= rto;
		@(posedge clk);
		cfg_index <= CFG_REREG_DELAY;
		cfg_wdata <= {8'd0, rrd};
		@(posedge clk);
		cfg_we <= 1'b0;
		hb_period = hb;
		reg_timeout = rto;
		rereg_delay = rrd;
	endtask

	task automatic check_directed_walk();
		send_beat(OP_TICK, 32'd0, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd90, 1'b0, 8'd4);
		send_beat(OP_TICK, 32'd91, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd95, 1'b1, 8'd4);
		send_beat(OP_TICK, 32'd96, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd97, 1'b1, 8'd4);
		send_beat(OP_TICK, 32'd187, 1'b0, 8'd3);
		send_beat(OP_TICK, 32'd188, 1'b1, 8'hFB);
		send_beat(OP_TEARDOWN, 32'd188, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd193, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd194, 1'b1, 8'd0);
		send_beat(OP_TICK, 32'd195, 1'b0, 8'd4);
		send_beat(OP_TICK, 32'd195, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		send_beat(OP_TICK, 32'd0, 1'b0, 8'd4);
		send_beat(OP_TEARDOWN, 32'hFFFF_FFFE, 1'b1, 8'hFF);
		send_beat(OP_TICK, 32'd3, 1'b0, 8'd0);
		send_beat(OP_TEARDOWN, 32'd10, 1'b0, 8'd4);
		send_beat(OP_TICK, 32'd458755, 1'b1, 8'd4);
		send_beat(OP_TICK, 32'd458855, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd458750, 1'b0, 8'd0);
		send_beat(OP_TICK, 32'd458751, 1'b1, 8'd0);
		send_beat(OP_TICK, 32'd458752, 1'b0, 8'd4);
		send_beat(OP_TEARDOWN, 32'd458753, 1'b1, 8'd4);
		wall_clock = 32'd458753;
		settle();
	endtask

	task automatic check_setting_extremes();
		load_settings(16'd0, 16'd0, 8'd0);
		repeat (80) send_session_beat();
		settle();
		load_settings(16'hFFFF, 16'hFFFF, 8'hFF);
		repeat (80) send_session_beat();
		settle();
		load_settings(16'd1, 16'd2, 8'hFF);
		repeat (80) send_session_beat();
		settle();
	endtask

	task automatic check_backpressure();
		idling = 1'b0;
		holds_asked++;
		repeat (40) send_session_beat();
		settle();
		repeat (20) send_session_beat();
		idling = 1'b1;
		settle();
	endtask

	task automatic load_random_settings();
		logic [15:0] hb;
		logic [15:0] rto;
		logic [7:0] rrd;
		case ($urandom_range(0, 3))
			0: hb = 16'($urandom_range(0, 3));
			1: hb = 16'($urandom_range(4, 40));
			2: hb = 16'($urandom_range(0, 65535));
			default: hb = 16'hFFFF;
		endcase
		case ($urandom_range(0, 2))
			0: rto = 16'($urandom_range(0, 10));
			1: rto = 16'($urandom_range(10, 200));
			default: rto = 16'($urandom_range(0, 65535));
		endcase
		rrd = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(0, 255));
		load_settings(hb, rto, rrd);
	endtask

	task automatic check_random_sessions();
		repeat (8) begin
			load_random_settings();
			repeat (160) send_session_beat();
			settle();
		end
	endtask

	task automatic check_steady_stream();
		idling = 1'b0;
		load_random_settings();
		repeat (200) send_session_beat();
		settle();
	endtask

	// receiver: short random stalls while idling is set, plus one long hold when asked
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (link_reports_due.size() == 0) begin
				flag_mismatch("beat with nothing due", m_tdata[31:0], 32'd0);
			end else begin
				want = link_reports_due.pop_front();
				if (m_tdata[2:0] !== want.link_state)
					flag_mismatch("link_state", m_tdata[2:0], want.link_state);
				if (m_tdata[3] !== want.link_ok)
					flag_mismatch("link_ok", m_tdata[3], want.link_ok);
				if (m_tdata[35:4] !== want.reg_count)
					flag_mismatch("reg_count", m_tdata[35:4], want.reg_count);
				if (m_tdata[36] !== want.apn_setup_pulse)
					flag_mismatch("apn_setup_pulse", m_tdata[36], want.apn_setup_pulse);
				if (m_tdata[37] !== want.teardown_pulse)
					flag_mismatch("teardown_pulse", m_tdata[37], want.teardown_pulse);
				if (m_tdata[38] !== want.service_tick_pulse)
					flag_mismatch("service_tick_pulse", m_tdata[38], want.service_tick_pulse);
				if (m_tdata[39] !== want.reboot_request)
					flag_mismatch("reboot_request", m_tdata[39], want.reboot_request);
			end
		end
	end

	initial begin : run_timer
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_directed_walk();
		check_setting_extremes();
		check_backpressure();
		check_random_sessions();
		check_steady_stream();
		if (mismatches == 0 && link_reports_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
